/* src/reversible_deque_buffer_assert.svh */
// Assertion macros used by the reversible deque buffer controller.
`ifndef REVERSIBLE_DEQUE_BUFFER_ASSERT_SVH
`define REVERSIBLE_DEQUE_BUFFER_ASSERT_SVH

// Checked on every rising edge of clock outside reset.
`define RDB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising edge of clock, reset included.
`define RDB_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* src/rdb_pkg.sv */
// Package with the request codes and element width of the reversible deque buffer.
package rdb_pkg;

   localparam int ELEM_W = 32;
   localparam int ACT_W  = 2;

   typedef enum logic [ACT_W-1:0] {
      ACT_INS_HEAD = 2'd0,
      ACT_INS_TAIL = 2'd1,
      ACT_REM_HEAD = 2'd2,
      ACT_REVERSE  = 2'd3
   } action_type;

endpackage

/* src/reversible_deque_buffer.sv */
// Top level of the reversible deque buffer: stream ports, controller and element store.
//
// A bounded double-ended queue of signed 32-bit words held in a ring of DEPTH
// entries. Each request word inserts at the head, inserts at the tail, removes
// the head or reverses the order; reversal only flips a direction flag and moves
// no data. Every request returns exactly one result word with a success flag,
// the removed value (zero unless a remove succeeded) and the count afterwards.
// Inserts, reversals and failed removes are settled in the cycle they are accepted, so
// such requests are accepted back to back; a successful remove goes through a read state,
// as it waits for the registered read of the element store. A new request
// is taken while the previous result still waits, provided the result register
// frees up in that cycle. No clearing pass is needed after reset.
module reversible_deque_buffer #(
   parameter int DEPTH = 256,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW    = $clog2(DEPTH + 1),
   localparam int RSP_W = ((1 + rdb_pkg::ELEM_W + CW + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [39:0]      req_tdata,  // action[1:0], value[33:2], zero fill
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata   // ok[0], removed_value[32:1], count, zero fill
);

   logic                       mem_wr_en;
   logic [AW-1:0]              mem_wr_addr;
   logic [rdb_pkg::ELEM_W-1:0] mem_wr_data;
   logic                       mem_rd_en;
   logic [AW-1:0]              mem_rd_addr;
   logic [rdb_pkg::ELEM_W-1:0] mem_rd_data;
   logic                       rsp_ok;
   logic [rdb_pkg::ELEM_W-1:0] rsp_removed;
   logic [CW-1:0]              rsp_count;

   rdb_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_action  (req_tdata[rdb_pkg::ACT_W-1:0]),
      .req_value   (req_tdata[rdb_pkg::ACT_W +: rdb_pkg::ELEM_W]),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_ok      (rsp_ok),
      .rsp_removed (rsp_removed),
      .rsp_count   (rsp_count),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   rdb_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_tdata = RSP_W'({rsp_count, rsp_removed, rsp_ok});

endmodule

/* src/rdb_ram.sv */
// Element store: single-port-write, registered-read synchronous memory.
module rdb_ram #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [rdb_pkg::ELEM_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic [rdb_pkg::ELEM_W-1:0] rd_data
);

   logic [rdb_pkg::ELEM_W-1:0] store_ff [DEPTH];
   logic [rdb_pkg::ELEM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/rdb_ctrl.sv */
// Ring pointers, direction flag, request sequencing and the result register.
`include "reversible_deque_buffer_assert.svh"

module rdb_ctrl #(
   parameter int DEPTH = 256,
   parameter int AW    = 8,
   parameter int CW    = 9
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [rdb_pkg::ACT_W-1:0]  req_action,
   input  logic [rdb_pkg::ELEM_W-1:0] req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_ok,
   output logic [rdb_pkg::ELEM_W-1:0] rsp_removed,
   output logic [CW-1:0]              rsp_count,
   output logic                       mem_wr_en,
   output logic [AW-1:0]              mem_wr_addr,
   output logic [rdb_pkg::ELEM_W-1:0] mem_wr_data,
   output logic                       mem_rd_en,
   output logic [AW-1:0]              mem_rd_addr,
   input  logic [rdb_pkg::ELEM_W-1:0] mem_rd_data
);

   typedef enum logic {ST_IDLE, ST_READ} state_type;

   state_type                  state_ff, state_in;
   logic [AW-1:0]              front_ff, front_in;
   logic [CW-1:0]              count_ff, count_in;
   logic                       rev_ff, rev_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_ok_ff, rsp_ok_in;
   logic [rdb_pkg::ELEM_W-1:0] rsp_removed_ff, rsp_removed_in;
   logic [CW-1:0]              rsp_count_ff, rsp_count_in;

   rdb_pkg::action_type act;
   logic                req_acc;
   logic                load;
   logic                full;
   logic                empty;
   logic                to_low;
   logic                rem_go;
   logic                rev_go;
   logic [CW-1:0]       count_m1;
   logic [AW-1:0]       front_dec;
   logic [AW-1:0]       front_inc;
   logic [AW-1:0]       high_addr;
   logic [AW-1:0]       push_addr;

   function automatic logic [AW-1:0] ring_add(logic [AW-1:0] base, logic [AW-1:0] offset);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, offset};
      if (sum >= (AW+1)'(DEPTH)) begin
         sum = sum - (AW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   assign act       = rdb_pkg::action_type'(req_action);
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_acc   = req_valid && req_ready;
   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign to_low    = (act == rdb_pkg::ACT_INS_HEAD) != rev_ff;
   assign rem_go    = req_acc && (act == rdb_pkg::ACT_REM_HEAD) && !empty;
   assign rev_go    = req_acc && (act == rdb_pkg::ACT_REVERSE);
   assign count_m1  = count_ff - CW'(1);
   assign front_dec = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - AW'(1);
   assign front_inc = (front_ff == AW'(DEPTH - 1)) ? '0 : front_ff + AW'(1);
   assign high_addr = ring_add(front_ff, count_m1[AW-1:0]);
   assign push_addr = ring_add(front_ff, count_ff[AW-1:0]);

   always_comb begin
      state_in       = state_ff;
      front_in       = front_ff;
      count_in       = count_ff;
      rev_in         = rev_ff;
      load           = 1'b0;
      rsp_ok_in      = 1'b1;
      rsp_removed_in = '0;
      rsp_count_in   = count_ff;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = to_low ? front_dec : push_addr;
      mem_wr_data    = req_value;
      mem_rd_en      = 1'b0;
      mem_rd_addr    = rev_ff ? high_addr : front_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (act) inside
                  rdb_pkg::ACT_INS_HEAD, rdb_pkg::ACT_INS_TAIL: begin
                     load = 1'b1;
                     if (full) begin
                        rsp_ok_in = 1'b0;
                     end else begin
                        mem_wr_en = 1'b1;
                        count_in  = count_ff + CW'(1);
                        if (to_low) begin
                           front_in = front_dec;
                        end
                     end
                  end
                  rdb_pkg::ACT_REM_HEAD: begin
                     if (empty) begin
                        load      = 1'b1;
                        rsp_ok_in = 1'b0;
                     end else begin
                        mem_rd_en = 1'b1;
                        count_in  = count_m1;
                        state_in  = ST_READ;
                        if (!rev_ff) begin
                           front_in = front_inc;
                        end
                     end
                  end
                  rdb_pkg::ACT_REVERSE: begin
                     load   = 1'b1;
                     rev_in = !rev_ff;
                  end
                  default: begin
                  end
               endcase
               rsp_count_in = count_in;
            end
         end
         ST_READ: begin
            load           = 1'b1;
            rsp_removed_in = mem_rd_data;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rev_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rev_ff       <= rev_in;
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            rsp_ok_ff      <= rsp_ok_in;
            rsp_removed_ff <= rsp_removed_in;
            rsp_count_ff   <= rsp_count_in;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_ok      = rsp_ok_ff;
   assign rsp_removed = rsp_removed_ff;
   assign rsp_count   = rsp_count_ff;

   `RDB_ASSERT(a_count_bound, count_ff <= CW'(DEPTH), "Element count exceeds the ring depth.")
   `RDB_ASSERT(a_read_slot_free, (state_ff == ST_READ) |-> !rsp_valid_ff, "Result slot busy.")
   `RDB_ASSERT(a_remove_reads, rem_go |=> (state_ff == ST_READ), "Remove skipped the read.")
   `RDB_ASSERT(a_reverse_keeps, rev_go |=> $stable({count_ff, front_ff}), "Ring moved.")
   `RDB_ASSERT_ALWAYS(a_no_overlap, !(mem_wr_en && mem_rd_en), "Write and read together.")

endmodule

/* sim/tb.sv */
// Self-checking testbench for the reversible deque buffer: directed table and random bursts.
`timescale 1ns / 100ps

module tb;

   localparam int DEPTH      = 256;
   localparam int RSP_W      = 48;
   localparam int ITEM_GOAL  = 2000;
   localparam int STALL_MAX  = 2000;
   localparam int TAIL_WAIT  = 16;
   localparam int IDLE_PCT   = 23;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mix_type;

   typedef struct packed {
      logic        ok;
      logic [31:0] removed;
      logic [8:0]  count;
   } deque_result_type;

   typedef struct packed {
      rdb_pkg::action_type act;
      logic [31:0]         val;
      logic                known;
      deque_result_type    res;
   } table_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [39:0]       req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;

   logic              no_idle = 1'b0;
   int                mismatches = 0;
   int                stall_cycles = 0;
   int                words_sent = 0;
   int                words_checked = 0;
   int                full_rejects = 0;
   int                empty_rejects = 0;
   int                reversals = 0;
   int                good_removes = 0;
   int                peak_held = 0;

   // Shadow copy of the ring and its pointers.
   logic [31:0]       shadow_slots [DEPTH];
   logic [7:0]        shadow_front = '0;
   logic [8:0]        shadow_held = '0;
   logic              shadow_flipped = 1'b0;

   deque_result_type  pending_results [$];

   // Expected results are typed in only where they are obvious.
   table_row_type directed_rows [25] = '{
      '{rdb_pkg::ACT_REM_HEAD, 32'h0000_0000, 1'b1, {1'b0, 32'h0000_0000, 9'd0}},
      '{rdb_pkg::ACT_REVERSE,  32'h0000_0000, 1'b1, {1'b1, 32'h0000_0000, 9'd0}},
      '{rdb_pkg::ACT_REVERSE,  32'hFFFF_FFFF, 1'b1, {1'b1, 32'h0000_0000, 9'd0}},
      '{rdb_pkg::ACT_INS_TAIL, 32'h8000_0000, 1'b1, {1'b1, 32'h0000_0000, 9'd1}},
      '{rdb_pkg::ACT_REM_HEAD, 32'h0000_0000, 1'b1, {1'b1, 32'h8000_0000, 9'd0}},
      '{rdb_pkg::ACT_INS_HEAD, 32'h7FFF_FFFF, 1'b1, {1'b1, 32'h0000_0000, 9'd1}},
      '{rdb_pkg::ACT_REVERSE,  32'h0000_0000, 1'b1, {1'b1, 32'h0000_0000, 9'd1}},
      '{rdb_pkg::ACT_REM_HEAD, 32'h0000_0000, 1'b1, {1'b1, 32'h7FFF_FFFF, 9'd0}},
      '{rdb_pkg::ACT_REM_HEAD, 32'h0000_0000, 1'b1, {1'b0, 32'h0000_0000, 9'd0}},
      '{rdb_pkg::ACT_REVERSE,  32'h0000_0000, 1'b1, {1'b1, 32'h0000_0000, 9'd0}},
      '{rdb_pkg::ACT_INS_HEAD, 32'hFFFF_FFFF, 1'b0, '0},
      '{rdb_pkg::ACT_INS_TAIL, 32'h0000_0000, 1'b0, '0},
      '{rdb_pkg::ACT_INS_HEAD, 32'h5555_5555, 1'b0, '0},
      '{rdb_pkg::ACT_INS_TAIL, 32'hAAAA_AAAA, 1'b0, '0},
      '{rdb_pkg::ACT_REVERSE,  32'h0000_0000, 1'b0, '0},
      '{rdb_pkg::ACT_INS_HEAD, 32'h1234_5678, 1'b0, '0},
      '{rdb_pkg::ACT_INS_TAIL, 32'h8000_0000, 1'b0, '0},
      '{rdb_pkg::ACT_REM_HEAD, 32'hFFFF_FFFF, 1'b0, '0},
      '{rdb_pkg::ACT_REM_HEAD, 32'h0000_0000, 1'b0, '0},
      '{rdb_pkg::ACT_REVERSE,  32'h7FFF_FFFF, 1'b0, '0},
      '{rdb_pkg::ACT_REM_HEAD, 32'h0000_0000, 1'b0, '0},
      '{rdb_pkg::ACT_REM_HEAD, 32'h0000_0000, 1'b0, '0},
      '{rdb_pkg::ACT_REM_HEAD, 32'h0000_0000, 1'b0, '0},
      '{rdb_pkg::ACT_REM_HEAD, 32'h0000_0000, 1'b0, '0},
      '{rdb_pkg::ACT_REM_HEAD, 32'h0000_0000, 1'b0, '0}
   };

   reversible_deque_buffer #(.DEPTH(DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // action[1:0], value[33:2], zero fill
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)    // ok[0], removed_value[32:1], count[41:33], zero fill
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic deque_result_type deque_apply(input rdb_pkg::action_type act,
                                                    input logic [31:0] val);
      deque_result_type r;
      logic             to_low;
      logic [7:0]       slot;
      r = '0;
      r.ok = 1'b1;
      case (act) inside
         rdb_pkg::ACT_INS_HEAD, rdb_pkg::ACT_INS_TAIL: begin
            if (shadow_held == DEPTH) begin
               r.ok = 1'b0;
            end else begin
               to_low = (act == rdb_pkg::ACT_INS_HEAD) != shadow_flipped;
               if (to_low) begin
                  shadow_front = shadow_front - 8'd1;
                  shadow_slots[shadow_front] = val;
               end else begin
                  slot = shadow_front + shadow_held[7:0];
                  shadow_slots[slot] = val;
               end
               shadow_held = shadow_held + 9'd1;
            end
         end
         rdb_pkg::ACT_REM_HEAD: begin
            if (shadow_held == 0) begin
               r.ok = 1'b0;
            end else if (shadow_flipped) begin
               slot = shadow_front + shadow_held[7:0] - 8'd1;
               r.removed = shadow_slots[slot];
               shadow_held = shadow_held - 9'd1;
            end else begin
               r.removed = shadow_slots[shadow_front];
               shadow_front = shadow_front + 8'd1;
               shadow_held = shadow_held - 9'd1;
            end
         end
         default: begin
            shadow_flipped = ~shadow_flipped;
         end
      endcase
      r.count = shadow_held;
      return r;
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic rdb_pkg::action_type pick_action(input traffic_mix_type mix);
      int roll;
      int insert_pct;
      roll = $urandom_range(99);
      insert_pct = (mix == MIX_FILL) ? 80 : (mix == MIX_DRAIN) ? 10 : 45;
      if (roll < 10)
         return rdb_pkg::ACT_REVERSE;
      else if (roll < 10 + insert_pct)
         return $urandom_range(1) ? rdb_pkg::ACT_INS_TAIL : rdb_pkg::ACT_INS_HEAD;
      else
         return rdb_pkg::ACT_REM_HEAD;
   endfunction

   task automatic send_word(input rdb_pkg::action_type act, input logic [31:0] val,
                            output deque_result_type predicted);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, val, act};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = deque_apply(act, val);
      words_sent++;
      if (act == rdb_pkg::ACT_REVERSE) reversals++;
      if (!predicted.ok && act == rdb_pkg::ACT_REM_HEAD) empty_rejects++;
      if (!predicted.ok && act != rdb_pkg::ACT_REM_HEAD) full_rejects++;
      if (predicted.ok && act == rdb_pkg::ACT_REM_HEAD) good_removes++;
      if (predicted.count > peak_held) peak_held = predicted.count;
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      deque_result_type want;
      deque_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.ok      = rsp_tdata[0];
         got.removed = rsp_tdata[32:1];
         got.count   = rsp_tdata[41:33];
         if (pending_results.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result word ok=%0b removed=%h count=%0d",
                     $time, got.ok, got.removed, got.count);
         end else begin
            want = pending_results.pop_front();
            words_checked++;
            if (got.ok !== want.ok) begin
               mismatches++;
               $display("%0t: ok expected %0b, actual %0b", $time, want.ok, got.ok);
            end
            if (got.removed !== want.removed) begin
               mismatches++;
               $display("%0t: removed_value expected %h, actual %h",
                        $time, want.removed, got.removed);
            end
            if (got.count !== want.count) begin
               mismatches++;
               $display("%0t: count expected %0d, actual %0d", $time, want.count, got.count);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_MAX) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_MAX);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      deque_result_type predicted;
      traffic_mix_type  mix;
      int               burst;
      int               burst_len;
      reset <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].act, directed_rows[i].val, predicted);
         pending_results.push_back(directed_rows[i].known ? directed_rows[i].res : predicted);
      end
      wait_for_drain();

      // Fill to the brim, empty it again, then mixed bursts; the third runs without idling.
      burst = 0;
      while (words_sent < ITEM_GOAL + 25) begin
         mix = (burst == 0) ? MIX_FILL : (burst == 1) ? MIX_DRAIN :
               traffic_mix_type'($urandom_range(2));
         burst_len = (burst < 2) ? 400 : $urandom_range(60, 300);
         no_idle = (burst == 2);
         repeat (burst_len) begin
            send_word(pick_action(mix), pick_value(), predicted);
            pending_results.push_back(predicted);
         end
         no_idle = 1'b0;
         wait_for_drain();
         burst++;
      end

      repeat (TAIL_WAIT) @(posedge clock);
      $display("Sent %0d request words in %0d bursts, checked %0d result words.",
               words_sent, burst, words_checked);
      $display("Reversals %0d, removes %0d, full rejects %0d, empty rejects %0d, peak %0d.",
               reversals, good_removes, full_rejects, empty_rejects, peak_held);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
